// ===== hw/rtl/iec104_float_measurand_parser_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the IEC 104 float measurand parser checker
// ---------------------------------------------------------------------------
`ifndef IEC104_FLOAT_MEASURAND_PARSER_MACROS_SVH
`define IEC104_FLOAT_MEASURAND_PARSER_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define IFMP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is asserted.
`define IFMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define IFMP_ASSERT_NEXT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ifmp_pkg.sv =====
// ---------------------------------------------------------------------------
// ifmp_pkg
// Types and constants shared by the IEC 104 float measurand parser.
// ---------------------------------------------------------------------------
package ifmp_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 9;
    localparam int ADDR_W      = 17;
    localparam int VALUE_W     = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - VALUE_W;

    localparam logic [7:0] TYPE_FLOAT  = 8'd13;
    localparam logic [7:0] CAUSE_SPONT = 8'd3;
    localparam logic [7:0] CAUSE_GI    = 8'd20;

    // Byte offsets inside an APDU
    localparam logic [POS_W-1:0] POS_START    = 9'd0;
    localparam logic [POS_W-1:0] POS_LEN      = 9'd1;
    localparam logic [POS_W-1:0] POS_TYPE     = 9'd6;
    localparam logic [POS_W-1:0] POS_COUNT    = 9'd7;
    localparam logic [POS_W-1:0] POS_CAUSE    = 9'd8;
    localparam logic [POS_W-1:0] POS_ADDR_LO  = 9'd12;
    localparam logic [POS_W-1:0] POS_ADDR_HI  = 9'd13;
    localparam logic [POS_W-1:0] POS_GI_FIRST = 9'd15;

    // Byte slots of an 8-byte spontaneous element
    localparam logic [2:0] EB_ADDR_LO  = 3'd0;
    localparam logic [2:0] EB_ADDR_HI  = 3'd1;
    localparam logic [2:0] EB_ADDR_EXT = 3'd2;
    localparam logic [2:0] EB_QUAL     = 3'd7;
    // Last value byte slot of a 5-byte interrogation element
    localparam logic [2:0] EB_GI_VAL_LAST = 3'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              package_start;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  point_address;
        logic [VALUE_W-1:0] value_bits;
        logic               last_in_apdu;
    } t_result;

endpackage

// ===== hw/rtl/ifmp_parse.sv =====
// ---------------------------------------------------------------------------
// ifmp_parse
// APDU framing state and element extraction, one byte per enabled cycle.
// ---------------------------------------------------------------------------
module ifmp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  ifmp_pkg::t_item   i_item,
    output ifmp_pkg::t_result o_res
);
    import ifmp_pkg::*;

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [7:0]         r_len,   n_len;
    logic [7:0]         r_type,  n_type;
    logic [7:0]         r_cause, n_cause;
    logic [7:0]         r_count, n_count;
    logic [15:0]        r_base,  n_base;
    logic [7:0]         r_idx,   n_idx;
    logic [2:0]         r_ebp,   n_ebp;
    logic [15:0]        r_eaddr, n_eaddr;
    logic [VALUE_W-1:0] r_vshift, n_vshift;

    logic [POS_W-1:0] w_pos;
    logic [7:0]       w_b;
    logic [8:0]       w_idx1;
    logic [11:0]      w_c3_end;
    logic [7:0]       w_gi_span;
    logic [11:0]      w_gi_need;
    logic             w_gi_ok;
    t_result          w_res;

    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_type   = r_type;
        n_cause  = r_cause;
        n_count  = r_count;
        n_base   = r_base;
        n_idx    = r_idx;
        n_ebp    = r_ebp;
        n_eaddr  = r_eaddr;
        n_vshift = r_vshift;
        w_res    = '0;

        w_b   = i_item.rx_byte;
        w_pos = i_item.package_start ? POS_START : r_pos;

        case (w_pos)
            POS_START: begin
                n_len    = '0;
                n_type   = '0;
                n_cause  = '0;
                n_count  = '0;
                n_base   = '0;
                n_idx    = '0;
                n_ebp    = '0;
                n_eaddr  = '0;
                n_vshift = '0;
            end
            POS_LEN:     n_len        = w_b;
            POS_TYPE:    n_type       = w_b;
            POS_COUNT:   n_count      = w_b;
            POS_CAUSE:   n_cause      = w_b;
            POS_ADDR_LO: n_base[7:0]  = w_b;
            POS_ADDR_HI: n_base[15:8] = w_b;
            default: ;
        endcase

        w_idx1    = {1'b0, r_idx} + 9'd1;
        w_c3_end  = 12'd27 + {1'b0, r_idx, 3'b000};
        w_gi_span = n_len - 8'd13;
        w_gi_need = {3'b000, w_idx1} * 12'd5;
        // element i exists when 5*(i+1) <= len - 13
        w_gi_ok   = (n_len >= 8'd13) && (w_gi_need <= {4'b0000, w_gi_span});

        if (n_type == TYPE_FLOAT && n_cause == CAUSE_SPONT && w_pos >= POS_ADDR_LO) begin
            case (r_ebp)
                EB_ADDR_LO:  n_eaddr[7:0]  = w_b;
                EB_ADDR_HI:  n_eaddr[15:8] = w_b;
                EB_ADDR_EXT: ;
                EB_QUAL: begin
                    if (r_idx < n_count) begin
                        w_res.valid         = 1'b1;
                        w_res.point_address = {1'b0, r_eaddr};
                        w_res.value_bits    = r_vshift;
                        // last when count reached or next element would overrun
                        w_res.last_in_apdu  = (w_idx1 == {1'b0, n_count}) ||
                                              (w_c3_end > ({4'b0000, n_len} + 12'd1));
                    end
                    n_idx = r_idx + 8'd1;
                end
                default: n_vshift = {w_b, r_vshift[VALUE_W-1:8]};
            endcase
            n_ebp = r_ebp + 3'd1;
        end else if (n_type == TYPE_FLOAT && n_cause == CAUSE_GI && w_pos >= POS_GI_FIRST) begin
            if (r_ebp <= EB_GI_VAL_LAST) begin
                n_vshift = {w_b, r_vshift[VALUE_W-1:8]};
                n_ebp    = r_ebp + 3'd1;
            end else begin
                if (w_gi_ok) begin
                    w_res.valid         = 1'b1;
                    w_res.point_address = {1'b0, r_base} + {9'd0, r_idx};
                    w_res.value_bits    = r_vshift;
                    w_res.last_in_apdu  = {4'b0000, w_gi_span} < (w_gi_need + 12'd5);
                end
                n_idx = r_idx + 8'd1;
                n_ebp = '0;
            end
        end

        if (w_pos != POS_START && w_pos >= ({1'b0, n_len} + 9'd1)) begin
            n_pos = POS_START;
        end else begin
            n_pos = w_pos + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_type   <= '0;
            r_cause  <= '0;
            r_count  <= '0;
            r_base   <= '0;
            r_idx    <= '0;
            r_ebp    <= '0;
            r_eaddr  <= '0;
            r_vshift <= '0;
        end else if (i_en) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_type   <= n_type;
            r_cause  <= n_cause;
            r_count  <= n_count;
            r_base   <= n_base;
            r_idx    <= n_idx;
            r_ebp    <= n_ebp;
            r_eaddr  <= n_eaddr;
            r_vshift <= n_vshift;
        end
    end

    assign o_res = w_res;

endmodule

// ===== hw/rtl/iec104_float_measurand_parser.sv =====
// ---------------------------------------------------------------------------
// iec104_float_measurand_parser
// Pulls short-float measurands (type 13) out of a received IEC 104 byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side takes one received byte per request on s_axis_tdata, with
//   s_axis_tuser high on the first byte of a package. Master side gives one
//   request per complete float element: address in tdata[16:0], raw single
//   value in tdata[48:17], tlast set on the final element of its APDU.
//   Bytes that complete no element give no output request.
// A taken byte sits in the input register; its result is registered in the
//   result register. Throughput: one byte per cycle while no result stalls;
//   each register holds one request, so the slave side keeps taking bytes
//   while a result waits, and stalls only once both are occupied.
// Reset (i_rst_n low, synchronous) empties both registers and clears all
//   framing state; the first byte after reset is treated as APDU byte 0.
// When m_axis_tready is low the result holds steady and at most one more
//   byte is taken before s_axis_tready drops.
// ---------------------------------------------------------------------------
module iec104_float_measurand_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ifmp_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    input  logic                              s_axis_tuser,  // [0] package_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ifmp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [16:0] point_address,
                                                             // [48:17] value_bits, [55:49] 0
    output logic                              m_axis_tlast   // last_in_apdu
);
    import ifmp_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    w_out_free;
    logic    w_proc;
    t_result w_res;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    ifmp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.rx_byte       <= s_axis_tdata;
            r_in.package_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= w_res.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.value_bits, r_out.point_address};
    assign m_axis_tlast  = r_out.last_in_apdu;

endmodule

// ===== hw/rtl/ifmp_checker.sv =====
// ---------------------------------------------------------------------------
// ifmp_checker
// Port-level checks for the float measurand parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "iec104_float_measurand_parser_macros.svh"

module ifmp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ifmp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast
);
    import ifmp_pkg::*;

    // stalled result must not change
    `IFMP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // padding above the value stays zero
    `IFMP_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:ADDR_W+VALUE_W] == '0, "nonzero tdata padding")

    // a fresh result must follow a byte taken on the slave side
    `IFMP_ASSERT_IMP(a_out_cause, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without a preceding byte")

    // reset empties the result register
    `IFMP_ASSERT_NEXT_ALL(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind iec104_float_measurand_parser ifmp_checker u_ifmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_iec104_float_measurand_parser.sv =====
// ---------------------------------------------------------------------------
// tb_iec104_float_measurand_parser
// Self-checking bench for the IEC 104 short-float measurand parser. Whole
// APDUs are streamed in byte by byte. A first table covers short, cut and
// foreign APDUs and the extremes of length, count and address. Random APDUs,
// noise bursts and broken packages follow. Every byte taken is run through
// a local parser model, and each output request is checked against the
// oldest expected measurand.
// ---------------------------------------------------------------------------
module tb_iec104_float_measurand_parser;
    import ifmp_pkg::*;

    localparam int DIR_ROWS       = 16;
    localparam int NO_COUNT       = -1;
    localparam int SPONT_ELEM_LEN = 8;
    localparam int GI_ELEM_LEN    = 5;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_LIMIT    = 10000;
    localparam int RAND_BYTES     = 80;
    localparam int RAND_RESULTS   = 8;

    typedef enum logic [1:0] {FILL_RAND, FILL_ONES, FILL_ZERO} t_fill;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_measurand;

    typedef struct packed {
        logic        st;
        logic [7:0]  len;
        logic [7:0]  typ;
        logic [7:0]  cnt;
        logic [7:0]  cause;
        logic [15:0] base;
        t_fill       fill;
        logic [8:0]  cut;     // bytes sent before abandoning, 0 = whole APDU
        int          n_exp;   // measurands this APDU must give, or NO_COUNT
    } t_apdu_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;  // [7:0] rx_byte
    logic                   s_axis_tuser = 1'b0; // [0] package_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [16:0] addr, [48:17] value, [55:49] 0
    logic                   m_axis_tlast;

    // parser model state
    logic [POS_W-1:0]   frame_pos = '0;
    logic [7:0]         frame_len = '0;
    logic [7:0]         frame_type = '0;
    logic [7:0]         frame_cause = '0;
    logic [7:0]         frame_count = '0;
    logic [15:0]        frame_base = '0;
    logic [7:0]         elem_idx = '0;
    logic [2:0]         elem_slot = '0;
    logic [15:0]        elem_addr = '0;
    logic [VALUE_W-1:0] value_acc = '0;

    t_measurand pending_measurands[$];
    t_measurand got_measurand;
    int         measurands_predicted = 0;
    int         mismatch_count = 0;
    int         fed_bytes = 0;
    bit         steady = 1'b0;    // no idling on either side while set

    iec104_float_measurand_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    task flag_mismatch(input string what, input logic [55:0] want, input logic [55:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    task clear_frame;
        frame_len   = '0;
        frame_type  = '0;
        frame_cause = '0;
        frame_count = '0;
        frame_base  = '0;
        elem_idx    = '0;
        elem_slot   = '0;
        elem_addr   = '0;
        value_acc   = '0;
    endtask

    // Advance the parser model by one accepted byte; queue any measurand
    task predict_byte(input logic [7:0] b, input logic st);
        int         idx;
        int         total;
        t_measurand m;
        idx = 0;
        total = 0;
        if (st)
            frame_pos = POS_START;

        if (frame_pos == POS_START)
            clear_frame();
        else if (frame_pos == POS_LEN)
            frame_len = b;
        else if (frame_pos == POS_TYPE)
            frame_type = b;
        else if (frame_pos == POS_COUNT)
            frame_count = b;
        else if (frame_pos == POS_CAUSE)
            frame_cause = b;
        else if (frame_pos == POS_ADDR_LO)
            frame_base[7:0] = b;
        else if (frame_pos == POS_ADDR_HI)
            frame_base[15:8] = b;

        if (frame_type == TYPE_FLOAT && frame_cause == CAUSE_SPONT
                && frame_pos >= POS_ADDR_LO) begin
            if (elem_slot == EB_ADDR_LO) begin
                elem_addr[7:0] = b;
            end else if (elem_slot == EB_ADDR_HI) begin
                elem_addr[15:8] = b;
            end else if (elem_slot == EB_QUAL) begin
                idx = int'(elem_idx);
                if (idx < int'(frame_count)) begin
                    m.addr  = {1'b0, elem_addr};
                    m.value = value_acc;
                    // last by count, or the next element would run past the APDU end
                    m.last  = (idx + 1 == int'(frame_count)) ||
                              (int'(POS_ADDR_LO) + SPONT_ELEM_LEN * (idx + 2) - 1 >
                               int'(frame_len) + 1);
                    pending_measurands.insert(pending_measurands.size(), m);
                    measurands_predicted++;
                end
                elem_idx = elem_idx + 8'd1;
            end else if (elem_slot != EB_ADDR_EXT) begin
                value_acc = {b, value_acc[VALUE_W-1:8]};
            end
            elem_slot = elem_slot + 3'd1;
        end else if (frame_type == TYPE_FLOAT && frame_cause == CAUSE_GI
                && frame_pos >= POS_GI_FIRST) begin
            if (elem_slot <= EB_GI_VAL_LAST) begin
                value_acc = {b, value_acc[VALUE_W-1:8]};
                elem_slot = elem_slot + 3'd1;
            end else begin
                if (int'(frame_len) + 2 >= int'(POS_GI_FIRST))
                    total = (int'(frame_len) + 2 - int'(POS_GI_FIRST)) / GI_ELEM_LEN;
                idx = int'(elem_idx);
                if (idx < total) begin
                    m.addr  = {1'b0, frame_base} + ADDR_W'(idx);
                    m.value = value_acc;
                    m.last  = (idx + 1 == total);
                    pending_measurands.insert(pending_measurands.size(), m);
                    measurands_predicted++;
                end
                elem_idx  = elem_idx + 8'd1;
                elem_slot = '0;
            end
        end

        if (frame_pos >= POS_LEN && int'(frame_pos) >= int'(frame_len) + 1)
            frame_pos = POS_START;
        else
            frame_pos = frame_pos + 9'd1;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task feed_byte(input logic [7:0] b, input logic st);
        while (!steady && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_byte(b, st);
        fed_bytes++;
        @(negedge i_clk);
    endtask

    task send_apdu(input logic st, input int len, input logic [7:0] typ,
                   input logic [7:0] cnt, input logic [7:0] cause,
                   input logic [15:0] base, input t_fill fill, input int cut);
        int         p;
        int         stop;
        logic [7:0] b;
        stop = (cut != 0 && cut < len + 2) ? cut : len + 2;
        for (p = 0; p < stop; p++) begin
            case (p)
                POS_LEN:     b = len[7:0];
                POS_TYPE:    b = typ;
                POS_COUNT:   b = cnt;
                POS_CAUSE:   b = cause;
                POS_ADDR_LO: b = base[7:0];
                POS_ADDR_HI: b = base[15:8];
                default: begin
                    case (fill)
                        FILL_ONES: b = 8'hFF;
                        FILL_ZERO: b = 8'h00;
                        default:   b = 8'($urandom_range(255));
                    endcase
                end
            endcase
            feed_byte(b, st && p == 0);
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 12);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_measurands.size() == 0) begin
                flag_mismatch("unexpected result", '0, {m_axis_tlast, m_axis_tdata[54:0]});
            end else begin
                got_measurand = pending_measurands.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] != got_measurand.addr)
                    flag_mismatch("point address", 56'(got_measurand.addr),
                                  56'(m_axis_tdata[ADDR_W-1:0]));
                if (m_axis_tdata[ADDR_W+VALUE_W-1:ADDR_W] != got_measurand.value)
                    flag_mismatch("value bits", 56'(got_measurand.value),
                                  56'(m_axis_tdata[ADDR_W+VALUE_W-1:ADDR_W]));
                if (m_axis_tdata[OUT_TDATA_W-1:ADDR_W+VALUE_W] != '0)
                    flag_mismatch("tdata padding", '0,
                                  56'(m_axis_tdata[OUT_TDATA_W-1:ADDR_W+VALUE_W]));
                if (m_axis_tlast != got_measurand.last)
                    flag_mismatch("last in apdu", 56'(got_measurand.last),
                                  56'(m_axis_tlast));
            end
        end
    end

    initial begin
        #200000;
        $display("tb_iec104_float_measurand_parser NOT OK");
        $finish;
    end

    initial begin
        t_apdu_row  rows [DIR_ROWS];
        int         r;
        int         before_row;
        int         random_base;
        int         results_base;
        int         kind;
        int         len;
        int         cut;
        int         pick;
        int         wait_cycles;
        logic       st;
        logic [7:0] typ;
        logic [7:0] cnt;
        logic [7:0] cause;
        t_fill      fill;

        //            st    len     type        cnt     cause        base       fill  cut n
        rows[0]  = '{1'b0, 8'd4,   8'd0,       8'd0,   8'd0,        16'h0000, FILL_ZERO, 9'd0, 0};
        rows[1]  = '{1'b1, 8'd0,   TYPE_FLOAT, 8'd1,   CAUSE_SPONT, 16'h0000, FILL_RAND, 9'd0, 0};
        rows[2]  = '{1'b1, 8'd18,  TYPE_FLOAT, 8'd1,   CAUSE_SPONT, 16'hFFFF, FILL_ONES, 9'd0, 1};
        rows[3]  = '{1'b1, 8'd26,  TYPE_FLOAT, 8'd2,   CAUSE_SPONT, 16'h1234, FILL_RAND, 9'd0, 2};
        // count says 5 but only 2 fit
        rows[4]  = '{1'b1, 8'd26,  TYPE_FLOAT, 8'd5,   CAUSE_SPONT, 16'h00A5, FILL_RAND, 9'd0, 2};
        // second element cut short by the APDU end
        rows[5]  = '{1'b1, 8'd21,  TYPE_FLOAT, 8'd2,   CAUSE_SPONT, 16'h5A5A, FILL_RAND, 9'd0, 1};
        rows[6]  = '{1'b1, 8'd18,  TYPE_FLOAT, 8'd0,   CAUSE_SPONT, 16'h0101, FILL_RAND, 9'd0, 0};
        rows[7]  = '{1'b1, 8'd23,  TYPE_FLOAT, 8'd2,   CAUSE_GI,    16'hFFFF, FILL_ZERO, 9'd0, 2};
        rows[8]  = '{1'b1, 8'd14,  TYPE_FLOAT, 8'd0,   CAUSE_GI,    16'h0020, FILL_RAND, 9'd0, 0};
        rows[9]  = '{1'b1, 8'd18,  TYPE_FLOAT, 8'd1,   8'd6,        16'h0001, FILL_RAND, 9'd0, 0};
        rows[10] = '{1'b1, 8'd18,  8'd9,       8'd1,   CAUSE_SPONT, 16'h0002, FILL_RAND, 9'd0, 0};
        // package restart in the middle of an APDU
        rows[11] = '{1'b1, 8'd26,  TYPE_FLOAT, 8'd2,   CAUSE_SPONT, 16'h4321, FILL_RAND, 9'd25, 1};
        rows[12] = '{1'b1, 8'd23,  TYPE_FLOAT, 8'd2,   CAUSE_GI,    16'h7FFF, FILL_RAND, 9'd20, 1};
        rows[13] = '{1'b1, 8'd34,  TYPE_FLOAT, 8'd2,   CAUSE_SPONT, 16'hBEEF, FILL_RAND, 9'd0, 2};
        rows[14] = '{1'b0, 8'd18,  TYPE_FLOAT, 8'd1,   CAUSE_GI,    16'h0400, FILL_RAND, 9'd0, 1};
        // longest APDU, abandoned after three elements
        rows[15] = '{1'b1, 8'd255, TYPE_FLOAT, 8'd255, CAUSE_SPONT, 16'h8000, FILL_RAND, 9'd36, 3};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            before_row = measurands_predicted;
            send_apdu(rows[r].st, int'(rows[r].len), rows[r].typ, rows[r].cnt,
                      rows[r].cause, rows[r].base, rows[r].fill, int'(rows[r].cut));
            if (rows[r].n_exp != NO_COUNT &&
                    measurands_predicted - before_row != rows[r].n_exp)
                flag_mismatch("measurands per apdu", 56'(rows[r].n_exp),
                              56'(measurands_predicted - before_row));
        end

        random_base  = fed_bytes;
        results_base = measurands_predicted;
        while (fed_bytes - random_base < RAND_BYTES ||
               measurands_predicted - results_base < RAND_RESULTS) begin
            steady = (fed_bytes - random_base >= 20) && (fed_bytes - random_base < 60);
            kind = $urandom_range(99);
            st   = ($urandom_range(9) < 7);
            pick = $urandom_range(99);
            fill = (pick < 3) ? FILL_ONES : (pick < 6) ? FILL_ZERO : FILL_RAND;
            len  = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(60, 10);
            cut  = ($urandom_range(9) == 0) ? $urandom_range(len + 1, 1) : 0;
            if (kind < 45) begin
                typ   = TYPE_FLOAT;
                cause = CAUSE_SPONT;
                cnt   = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(6));
            end else if (kind < 85) begin
                typ   = TYPE_FLOAT;
                cause = CAUSE_GI;
                cnt   = 8'($urandom_range(255));
            end else begin
                typ   = 8'($urandom_range(255));
                cause = 8'($urandom_range(255));
                cnt   = 8'($urandom_range(255));
            end
            if (kind >= 93) begin
                // noise burst, package starts sprinkled in
                repeat ($urandom_range(20, 1))
                    feed_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
            end else begin
                send_apdu(st, len, typ, cnt, cause, 16'($urandom_range(16'hFFFF)), fill, cut);
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_measurands.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_measurands.size() != 0)
            flag_mismatch("measurands never seen", '0, 56'(pending_measurands.size()));

        if (mismatch_count == 0)
            $display("tb_iec104_float_measurand_parser OK");
        else
            $display("tb_iec104_float_measurand_parser NOT OK");
        $finish;
    end

endmodule
